// File: hdl/sirt_pkg.sv
package sirt_pkg;

   // Symbol table geometry
   localparam int MAX_SYMBOLS = 32;
   localparam int SYM_W       = 8;
   localparam int TABLE_W     = MAX_SYMBOLS * SYM_W;
   localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
   localparam int COUNT_W     = 6;

   // Value and digit bookkeeping
   localparam int VALUE_W     = 32;
   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int DIG_CNT_W   = $clog2(VALUE_W + 1);

   // Item queue between front and back; the output queue has the same depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] REG_SYMBOL_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_LOW      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_MID_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_MID_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_HIGH     = 3'd4;

   localparam logic [SYM_W-1:0] MINUS_BYTE = 8'h2D;
   localparam logic [SYM_W-1:0] PLUS_BYTE  = 8'h2B;

   // One classified value: sign and magnitude
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } item_type;

   // Checked symbol table; radix is zero when the table is unusable
   typedef struct packed {
      logic [COUNT_W-1:0] radix;
      logic [TABLE_W-1:0] symbols;
   } table_type;

endpackage

// File: hdl/sirt_table.sv
module sirt_table import sirt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  busy,
   output table_type             tbl
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TABLE_W-1:0] symbols_ff, symbols_in;
   logic               busy_ff, busy_in;
   logic [DIGIT_W-1:0] idx_ff, idx_in;
   logic               bad_ff, bad_in;
   logic [COUNT_W-1:0] radix_ff, radix_in;

   logic               csr_write;
   logic [COUNT_W-1:0] used;
   logic [SYM_W-1:0]   cur;
   logic               in_range;
   logic               dup;
   logic               bad_now;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Clamp the count to the table size
   assign used = (count_ff > COUNT_W'(MAX_SYMBOLS)) ? COUNT_W'(MAX_SYMBOLS) : count_ff;

   // Check one symbol per cycle, while no register write arrives, against the sign bytes and all later used symbols
   assign cur      = symbols_ff[{idx_ff, 3'b000} +: SYM_W];
   assign in_range = {1'b0, idx_ff} < used;

   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         if ((COUNT_W'(j) > {1'b0, idx_ff}) && (COUNT_W'(j) < used) &&
             (symbols_ff[j*SYM_W +: SYM_W] == cur)) begin
            dup = 1'b1;
         end
      end
   end

   assign bad_now = bad_ff |
                    (in_range & ((cur == PLUS_BYTE) | (cur == MINUS_BYTE) | dup));

   // Register writes restart the sweep
   always_comb begin
      count_in   = count_ff;
      symbols_in = symbols_ff;
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      bad_in     = bad_ff;
      radix_in   = radix_ff;
      if (csr_write) begin
         busy_in = 1'b1;
         idx_in  = '0;
         bad_in  = 1'b0;
         case (csr_index)
            REG_SYMBOL_COUNT:     count_in = csr_data[COUNT_W-1:0];
            REG_SYMBOLS_LOW:      symbols_in[0*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            REG_SYMBOLS_MID_LOW:  symbols_in[1*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            REG_SYMBOLS_MID_HIGH: symbols_in[2*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            REG_SYMBOLS_HIGH:     symbols_in[3*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            default:              busy_in = 1'b1;
         endcase
      end else if (busy_ff) begin
         bad_in = bad_now;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == DIGIT_W'(MAX_SYMBOLS - 1)) begin
            busy_in  = 1'b0;
            radix_in = ((used < COUNT_W'(2)) || bad_now) ? '0 : used;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         symbols_ff <= '0;
         busy_ff    <= 1'b0;
         idx_ff     <= '0;
         bad_ff     <= 1'b0;
         radix_ff   <= '0;
      end else begin
         count_ff   <= count_in;
         symbols_ff <= symbols_in;
         busy_ff    <= busy_in;
         idx_ff     <= idx_in;
         bad_ff     <= bad_in;
         radix_ff   <= radix_in;
      end
   end

   assign busy        = busy_ff;
   assign tbl.radix   = radix_ff;
   assign tbl.symbols = symbols_ff;

endmodule

// File: hdl/sirt_front.sv
module sirt_front import sirt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      table_busy,
   output logic                      item_valid,
   input  logic                      item_ready,
   output item_type                  item
);

   item_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   logic                enq;
   logic                deq;
   logic [VALUE_W-1:0]  raw;
   item_type            classified;

   // Hold off input while the queue is full or the table is being checked
   assign full = (cnt_ff == QCNT_W'(QUEUE_DEPTH)) | table_busy;
   assign enq  = push & ~full;

   assign item_valid = (cnt_ff != '0);
   assign deq        = item_valid & item_ready;
   assign item       = queue_ff[rd_ptr_ff];

   // Split into sign and magnitude; the most negative value maps to 2^31
   assign raw            = $unsigned(req_value);
   assign classified.neg = raw[VALUE_W-1];
   assign classified.mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({enq, deq})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// File: hdl/sirt_back.sv
module sirt_back import sirt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   output logic             item_ready,
   input  item_type         item,
   input  table_type        tbl,
   output logic             empty,
   input  logic             pop,
   output logic [SYM_W-1:0] rsp_text_byte,
   output logic             rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SIGN = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   typedef struct packed {
      logic [SYM_W-1:0] text_byte;
      logic             last;
   } word_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   radix_ff, radix_in;
   logic [VALUE_W-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic [DIGIT_W-1:0]   stack_ff [VALUE_W];
   word_type             ofifo_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    owr_ff, owr_in;
   logic [QPTR_W-1:0]    ord_ff, ord_in;
   logic [QCNT_W-1:0]    ocnt_ff, ocnt_in;

   logic [COUNT_W-1:0]   trial;
   logic                 ge;
   logic [DIGIT_W-1:0]   rem_next;
   logic [VALUE_W-1:0]   quo_next;
   logic                 stack_we;
   logic [DIGIT_W-1:0]   top_idx;
   logic [DIGIT_W-1:0]   top_digit;
   logic [SYM_W-1:0]     top_sym;
   logic                 out_full;
   logic                 out_push;
   logic                 out_pop;
   word_type             out_data;

   // One restoring divide step: bring in the next dividend bit
   assign trial    = {rem_ff, quo_ff[VALUE_W-1]};
   assign ge       = (trial >= radix_ff);
   assign rem_next = ge ? DIGIT_W'(trial - radix_ff) : trial[DIGIT_W-1:0];
   assign quo_next = {quo_ff[VALUE_W-2:0], ge};

   // Most significant digit sits on top of the stack
   assign top_idx   = DIGIT_W'(dig_cnt_ff - 1'b1);
   assign top_digit = stack_ff[top_idx];
   assign top_sym   = tbl.symbols[{top_digit, 3'b000} +: SYM_W];

   assign out_full = (ocnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (ocnt_ff == '0);
   assign out_pop  = pop & ~empty;

   // Sequencer: sign, digit extraction, digit emission
   always_comb begin
      state_in   = state_ff;
      radix_in   = radix_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      item_ready = 1'b0;
      stack_we   = 1'b0;
      out_push   = 1'b0;
      out_data   = '0;
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               radix_in   = tbl.radix;
               quo_in     = item.mag;
               rem_in     = '0;
               bit_cnt_in = '0;
               dig_cnt_in = '0;
               if (item.neg) begin
                  state_in = ST_SIGN;
               end else if (tbl.radix != '0) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_SIGN: begin
            if (!out_full) begin
               out_push           = 1'b1;
               out_data.text_byte = MINUS_BYTE;
               out_data.last      = (radix_ff == '0);
               state_in           = (radix_ff == '0) ? ST_IDLE : ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in     = quo_next;
            rem_in     = rem_next;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               stack_we   = 1'b1;
               dig_cnt_in = dig_cnt_ff + 1'b1;
               rem_in     = '0;
               if (quo_next == '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               out_push           = 1'b1;
               out_data.text_byte = top_sym;
               out_data.last      = (dig_cnt_ff == DIG_CNT_W'(1));
               dig_cnt_in         = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output queue pointers and count
   always_comb begin
      owr_in = out_push ? owr_ff + 1'b1 : owr_ff;
      ord_in = out_pop ? ord_ff + 1'b1 : ord_ff;
      case ({out_push, out_pop})
         2'b10:   ocnt_in = ocnt_ff + 1'b1;
         2'b01:   ocnt_in = ocnt_ff - 1'b1;
         default: ocnt_in = ocnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         radix_ff   <= '0;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         owr_ff     <= '0;
         ord_ff     <= '0;
         ocnt_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         radix_ff   <= radix_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         owr_ff     <= owr_in;
         ord_ff     <= ord_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   // Datapath and storage
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (stack_we) begin
         stack_ff[dig_cnt_ff[DIGIT_W-1:0]] <= rem_next;
      end
      if (out_push) begin
         ofifo_ff[owr_ff] <= out_data;
      end
   end

   assign rsp_text_byte = ofifo_ff[ord_ff].text_byte;
   assign rsp_last      = ofifo_ff[ord_ff].last;

`ifndef SYNTHESIS
   a_no_out_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("output word pushed into a full queue");

   a_div_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (radix_ff >= COUNT_W'(2)))
      else $error("dividing with a radix below two");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (dig_cnt_ff != '0) && (dig_cnt_ff <= DIG_CNT_W'(VALUE_W)))
      else $error("digit stack count out of range while emitting");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_push && dig_cnt_ff == DIG_CNT_W'(1)) |=>
      (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the final digit");
`endif

endmodule

// File: hdl/signed_integer_to_radix_text_core.sv
// Flow: a taken value waits in the front queue; the back end takes it when idle, emits a minus sign
// first if it is negative, then, with a usable table, divides out the digits bit-serially and emits
// them most significant first, one digit per cycle while the output queue has room. A new value
// enters the back end only after the last word of the previous one is queued.
// Reset: synchronous, active high; the radix clears to zero, giving an unusable table (no digits).
// After each register write all 32 table slots are checked in a sweep; full stays high meanwhile.
module signed_integer_to_radix_text_core import sirt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      empty,
   input  logic                      pop,
   output logic [SYM_W-1:0]          rsp_text_byte,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   table_type tbl;
   logic      table_busy;
   logic      item_valid;
   logic      item_ready;
   item_type  item;

   // Register file and table check
   sirt_table u_table (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (table_busy),
      .tbl       (tbl)
   );

   // Accept and classify
   sirt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_value  (req_value),
      .table_busy (table_busy),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // Convert and emit text
   sirt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .tbl           (tbl),
      .empty         (empty),
      .pop           (pop),
      .rsp_text_byte (rsp_text_byte),
      .rsp_last      (rsp_last)
   );

endmodule

// File: verif/tb_signed_integer_to_radix_text_core.sv
module tb_signed_integer_to_radix_text_core;
   import sirt_pkg::*;

   localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 1200;
   localparam int LONG_HOLD_OFF = 1500;
   localparam int QUIET_LIMIT   = 20000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_VALUES  = 26;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {
      TABLE_VALID,
      TABLE_SHORT,
      TABLE_PLUS,
      TABLE_MINUS,
      TABLE_REPEAT
   } table_kind_type;

   typedef struct {
      logic [SYM_W-1:0] text_byte;
      logic             last;
   } char_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [SYM_W-1:0]          rsp_text_byte;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // Predictor copy of the registers
   logic [COUNT_W-1:0]    cfg_count = '0;
   logic [CSR_DATA_W-1:0] cfg_words [4] = '{default: '0};

   // Table being prepared before it is written
   logic [CSR_DATA_W-1:0] plan_count;
   logic [CSR_DATA_W-1:0] plan_words [4];

   logic signed [VALUE_W-1:0] values_to_send [$];
   char_word_type             text_words_due [$];

   bit send_taken = 1'b0;
   bit idle_on = 1'b1;
   bit hold_off_request = 1'b0;
   int send_gap = 0;
   int pop_gap = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int values_sent = 0;
   int words_checked = 0;
   int table_settings = 0;

   signed_integer_to_radix_text_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_value     (req_value),
      .empty         (empty),
      .pop           (pop),
      .rsp_text_byte (rsp_text_byte),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [SYM_W-1:0] table_symbol(int i);
      return cfg_words[i / 8][(i % 8) * 8 +: 8];
   endfunction

   // Radix of the current table, zero when the table cannot be used
   function automatic int unsigned usable_radix();
      int unsigned n;
      int i, j;
      logic [SYM_W-1:0] s;
      n = (cfg_count > MAX_SYMBOLS) ? MAX_SYMBOLS : cfg_count;
      if (n < 2) return 0;
      for (i = 0; i < n; i++) begin
         s = table_symbol(i);
         if (s == PLUS_BYTE || s == MINUS_BYTE) return 0;
         for (j = i + 1; j < n; j++) begin
            if (table_symbol(j) == s) return 0;
         end
      end
      return n;
   endfunction

   // Queue the text words that one value turns into
   function automatic void predict_text(logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] mag;
      logic [4:0] digits [$];
      int unsigned radix;
      int i;
      radix = usable_radix();
      mag = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
      if (radix != 0) begin
         do begin
            digits.push_back(5'(mag % radix));
            mag = mag / radix;
         end while (mag != 0);
      end
      if (raw[VALUE_W-1]) begin
         text_words_due.push_back('{MINUS_BYTE, digits.size() == 0});
      end
      for (i = digits.size() - 1; i >= 0; i--) begin
         text_words_due.push_back('{table_symbol(digits[i]), i == 0});
      end
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3: v = $urandom;
         4, 5: v = $urandom_range(0, 1000);
         6: v = $urandom >> $urandom_range(0, 31);
         7: begin
            case ($urandom_range(0, 3))
               0: v = MOST_NEGATIVE;
               1: v = MOST_POSITIVE;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = $urandom_range(0, 40);
      endcase
      if (pick >= 4 && pick != 7 && $urandom_range(0, 1) == 1) v = 32'd0 - v;
      return v;
   endfunction

   function automatic void put_symbol(int i, logic [SYM_W-1:0] s);
      plan_words[i / 8][(i % 8) * 8 +: 8] = s;
   endfunction

   // Build a table of the given kind; count goes in the low bits of a random word
   task automatic plan_table(input table_kind_type kind, input int count);
      bit taken [256];
      logic [SYM_W-1:0] s;
      int i, used, spot, other;
      taken[PLUS_BYTE] = 1'b1;
      taken[MINUS_BYTE] = 1'b1;
      for (i = 0; i < MAX_SYMBOLS; i++) begin
         do s = SYM_W'($urandom_range(0, 255)); while (taken[s]);
         taken[s] = 1'b1;
         put_symbol(i, s);
      end
      plan_count = {$urandom, $urandom};
      plan_count[COUNT_W-1:0] = count[COUNT_W-1:0];
      used = (count > MAX_SYMBOLS) ? MAX_SYMBOLS : count;
      spot = (used > 0) ? $urandom_range(0, used - 1) : 0;
      case (kind)
         TABLE_PLUS: put_symbol(spot, PLUS_BYTE);
         TABLE_MINUS: put_symbol(spot, MINUS_BYTE);
         TABLE_REPEAT: begin
            other = (spot + $urandom_range(1, used - 1)) % used;
            put_symbol(spot, plan_words[other / 8][(other % 8) * 8 +: 8]);
         end
         TABLE_VALID: begin
            // repeat a symbol outside the used range; it must not matter
            if (used < MAX_SYMBOLS) put_symbol(used, plan_words[0][7:0]);
         end
         default: ;
      endcase
   endtask

   // Write one register and mirror it once the handshake completes
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SYMBOL_COUNT: cfg_count = data[COUNT_W-1:0];
         REG_SYMBOLS_LOW: cfg_words[0] = data;
         REG_SYMBOLS_MID_LOW: cfg_words[1] = data;
         REG_SYMBOLS_MID_HIGH: cfg_words[2] = data;
         REG_SYMBOLS_HIGH: cfg_words[3] = data;
         default: ;
      endcase
   endtask

   task automatic program_table();
      write_csr(REG_SYMBOL_COUNT, plan_count);
      write_csr(REG_SYMBOLS_LOW, plan_words[0]);
      write_csr(REG_SYMBOLS_MID_LOW, plan_words[1]);
      write_csr(REG_SYMBOLS_MID_HIGH, plan_words[2]);
      write_csr(REG_SYMBOLS_HIGH, plan_words[3]);
      if ($urandom_range(0, 2) == 0) begin
         write_csr(CSR_IDX_W'(REG_SYMBOLS_HIGH + 1 + $urandom_range(0, 2)),
                   {$urandom, $urandom});
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      table_settings++;
   endtask

   // Wait until every value is taken and every word is back, then let the block settle
   task automatic drain();
      while (values_to_send.size() != 0 || text_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: note accepted values at the rising edge
   always @(posedge clock) begin
      send_taken = !reset && push && !full;
      if (send_taken) begin
         predict_text(req_value);
         void'(values_to_send.pop_front());
         values_sent++;
      end
   end

   // Sender: offer the next value at the falling edge, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!(push && !send_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 8);
            push <= 1'b0;
         end else if (values_to_send.size() != 0) begin
            push <= 1'b1;
            req_value <= values_to_send[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Receiver: drop pop during a long hold-off or a random burst
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_left = LONG_HOLD_OFF;
         hold_off_request = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         pop_gap = $urandom_range(0, 8);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Receiver: check each popped word against the oldest prediction
   always @(posedge clock) begin : check_text
      char_word_type due;
      if (!reset && pop && !empty) begin
         words_checked++;
         if (text_words_due.size() == 0) begin
            note_mismatch($sformatf("unexpected word text_byte=%h last=%b",
                                    rsp_text_byte, rsp_last));
         end else begin
            due = text_words_due.pop_front();
            if (rsp_text_byte !== due.text_byte)
               note_mismatch($sformatf("text_byte expected %h got %h",
                                       due.text_byte, rsp_text_byte));
            if (rsp_last !== due.last)
               note_mismatch($sformatf("last expected %b got %b (text_byte %h)",
                                       due.last, rsp_last, due.text_byte));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int p, k;
      table_kind_type kind;
      int count;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Table left by reset: no digits, only the sign
      values_to_send.push_back(7);
      values_to_send.push_back(-7);
      drain();

      // Decimal table, plus writes to unused indexes
      for (k = 1; k <= 3; k++) write_csr(CSR_IDX_W'(REG_SYMBOLS_HIGH + k), {$urandom, $urandom});
      plan_table(TABLE_VALID, 10);
      for (k = 0; k < 10; k++) put_symbol(k, SYM_W'(8'h30 + k));
      program_table();
      values_to_send.push_back(0);
      values_to_send.push_back(9);
      values_to_send.push_back(10);
      values_to_send.push_back(-1);
      values_to_send.push_back(MOST_POSITIVE);
      values_to_send.push_back(MOST_NEGATIVE);
      drain();

      // Binary with a zero byte as a symbol
      plan_table(TABLE_VALID, 2);
      put_symbol(0, 8'h00);
      put_symbol(1, 8'h31);
      program_table();
      values_to_send.push_back(0);
      values_to_send.push_back(MOST_NEGATIVE);
      values_to_send.push_back(MOST_POSITIVE);
      values_to_send.push_back(-5);
      drain();

      // Count above the table size clamps to the full table
      plan_table(TABLE_VALID, 63);
      program_table();
      values_to_send.push_back(MOST_NEGATIVE);
      values_to_send.push_back(MOST_POSITIVE);
      values_to_send.push_back(31);
      values_to_send.push_back(32);
      drain();

      // Unusable tables: plus sign, minus sign, repeated symbol, too few symbols
      plan_table(TABLE_PLUS, 16);
      program_table();
      values_to_send.push_back(5);
      values_to_send.push_back(-5);
      drain();
      plan_table(TABLE_MINUS, 32);
      program_table();
      values_to_send.push_back(3);
      values_to_send.push_back(-3);
      drain();
      plan_table(TABLE_REPEAT, 20);
      program_table();
      values_to_send.push_back(100);
      values_to_send.push_back(-100);
      drain();
      plan_table(TABLE_SHORT, 1);
      program_table();
      values_to_send.push_back(0);
      values_to_send.push_back(-9);
      drain();

      // Random tables and values; quiet handshakes in the last phase
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0: kind = TABLE_SHORT;
            1: kind = TABLE_PLUS;
            2: kind = TABLE_MINUS;
            3: kind = TABLE_REPEAT;
            default: kind = TABLE_VALID;
         endcase
         if (p <= 1) kind = TABLE_VALID;
         case (kind)
            TABLE_SHORT: count = $urandom_range(0, 1);
            TABLE_VALID: count = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 63)
                                                             : $urandom_range(2, 32);
            default: count = $urandom_range(2, 63);
         endcase
         if (p == 0) count = 32;
         if (p == 1) count = 2;
         plan_table(kind, count);
         program_table();
         if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
         // hold the receiver off while values keep coming so the block fills
         if (p == 0) hold_off_request = 1'b1;
         for (k = 0; k < PHASE_VALUES; k++) values_to_send.push_back(random_value());
         drain();
      end

      $display("covered %0d values and %0d text words over %0d table settings",
               values_sent, words_checked, table_settings);
      $display("tables ran from radix 2 to 32, with clamped counts, unusable tables"
               , " and writes to unused indexes");
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: signed_integer_to_radix_text_core.f
hdl/sirt_pkg.sv
hdl/sirt_table.sv
hdl/sirt_front.sv
hdl/sirt_back.sv
hdl/signed_integer_to_radix_text_core.sv
verif/tb_signed_integer_to_radix_text_core.sv
